@@ hw/rtl/rgd_pkg.sv @@
// Package: shared types, constants and font lookup for the draw stream block.
package rgd_pkg;

  localparam logic [7:0] CMD_COLSET = 8'h2A;
  localparam logic [7:0] CMD_ROWSET = 8'h2B;
  localparam logic [7:0] CMD_MEMWR  = 8'h2C;
  localparam logic [3:0] CELL_W     = 4'd6;
  localparam logic [3:0] CELL_H     = 4'd8;

  localparam logic [0:0] CFG_PANEL_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_PANEL_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_PIXEL = 2'd2
  } item_kind_e;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_WINDOW,
    BE_CHAR,
    BE_FILL
  } be_state_e;

  // Classified job handed from the front to the back.
  typedef struct packed {
    logic        is_char;
    logic [7:0]  x0;
    logic [7:0]  y0;
    logic [7:0]  x1;
    logic [7:0]  y1;
    logic [15:0] count;
    logic [7:0]  char_code;
    logic [15:0] fg;
    logic [15:0] bg;
  } job_t;

  // Column bitmap of one glyph column; bit r is row r.
  function automatic logic [7:0] font_col(input logic [7:0] code, input logic [2:0] col);
    logic [39:0] g;
    begin
      case (code)
        8'h3E: g = 40'h08_1C_3E_1C_08;
        8'h2A: g = 40'h14_08_3E_08_14;
        8'h3A: g = 40'h00_36_36_00_00;
        8'h2F: g = 40'h20_10_08_04_02;
        8'h30: g = 40'h3E_51_49_45_3E;
        8'h31: g = 40'h00_42_7F_40_00;
        8'h32: g = 40'h42_61_51_49_46;
        8'h33: g = 40'h21_41_45_4B_31;
        8'h34: g = 40'h18_14_12_7F_10;
        8'h35: g = 40'h27_45_45_45_39;
        8'h36: g = 40'h3C_4A_49_49_30;
        8'h37: g = 40'h01_71_09_05_03;
        8'h38: g = 40'h36_49_49_49_36;
        8'h39: g = 40'h06_49_49_29_1E;
        8'h41: g = 40'h7E_11_11_11_7E;
        8'h42: g = 40'h7F_49_49_49_36;
        8'h43: g = 40'h3E_41_41_41_22;
        8'h44: g = 40'h7F_41_41_22_1C;
        8'h45: g = 40'h7F_49_49_49_41;
        8'h46: g = 40'h7F_09_09_09_01;
        8'h47: g = 40'h3E_41_49_49_7A;
        8'h48: g = 40'h7F_08_08_08_7F;
        8'h49: g = 40'h00_41_7F_41_00;
        8'h4A: g = 40'h20_40_41_3F_01;
        8'h4B: g = 40'h7F_08_14_22_41;
        8'h4C: g = 40'h7F_40_40_40_40;
        8'h4D: g = 40'h7F_02_0C_02_7F;
        8'h4E: g = 40'h7F_04_08_10_7F;
        8'h4F: g = 40'h3E_41_41_41_3E;
        8'h50: g = 40'h7F_09_09_09_06;
        8'h51: g = 40'h3E_41_51_21_5E;
        8'h52: g = 40'h7F_09_19_29_46;
        8'h53: g = 40'h46_49_49_49_31;
        8'h54: g = 40'h01_01_7F_01_01;
        8'h55: g = 40'h3F_40_40_40_3F;
        8'h56: g = 40'h1F_20_40_20_1F;
        8'h57: g = 40'h3F_40_38_40_3F;
        8'h58: g = 40'h63_14_08_14_63;
        8'h59: g = 40'h07_08_70_08_07;
        8'h5A: g = 40'h61_51_49_45_43;
        default: g = 40'h0;
      endcase
      case (col)
        3'd0: font_col = g[39:32];
        3'd1: font_col = g[31:24];
        3'd2: font_col = g[23:16];
        3'd3: font_col = g[15:8];
        3'd4: font_col = g[7:0];
        default: font_col = 8'h00;
      endcase
    end
  endfunction

endpackage

@@ hw/rtl/rgd_front.sv @@
// Front end: accept requests, clip or reject them, and register a job.
module rgd_front
  import rgd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  pos_x_i,
  input  logic [7:0]  pos_y_i,
  input  logic [7:0]  rect_width_i,
  input  logic [7:0]  rect_height_i,
  input  logic [7:0]  char_code_i,
  input  logic [15:0] fg_color_i,
  input  logic [15:0] bg_color_i,
  input  logic [7:0]  panel_width_i,
  input  logic [7:0]  panel_height_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output job_t        job_o
);

  // Stage 1: clip and classify.
  logic       s1_valid_q;
  logic       s1_char_q;
  logic [7:0] s1_x_q, s1_y_q, s1_w_q, s1_h_q, s1_code_q;
  logic [15:0] s1_fg_q, s1_bg_q;
  logic       s1_ready;

  // Stage 2 handshake, needed by stage 1.
  logic s2_valid_q;
  logic s2_ready;

  logic [8:0] room_x, room_y;
  logic [7:0] w_clip, h_clip;
  logic       keep;

  assign room_x = {1'b0, panel_width_i} - {1'b0, pos_x_i};
  assign room_y = {1'b0, panel_height_i} - {1'b0, pos_y_i};

  always_comb begin
    w_clip = ({1'b0, rect_width_i} > room_x) ? room_x[7:0] : rect_width_i;
    h_clip = ({1'b0, rect_height_i} > room_y) ? room_y[7:0] : rect_height_i;
    if (req_type_i) begin
      keep = ({1'b0, pos_x_i} + 9'(CELL_W) <= {1'b0, panel_width_i}) &&
             ({1'b0, pos_y_i} + 9'(CELL_H) <= {1'b0, panel_height_i});
    end else begin
      keep = (pos_x_i < panel_width_i) && (pos_y_i < panel_height_i) &&
             (rect_width_i != 8'd0) && (rect_height_i != 8'd0);
    end
  end

  assign req_ready_o = s1_ready;
  assign s1_ready    = !s1_valid_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= req_valid_i && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && s1_ready) begin
      s1_char_q <= req_type_i;
      s1_x_q    <= pos_x_i;
      s1_y_q    <= pos_y_i;
      s1_w_q    <= req_type_i ? 8'(CELL_W) : w_clip;
      s1_h_q    <= req_type_i ? 8'(CELL_H) : h_clip;
      s1_code_q <= char_code_i;
      s1_fg_q   <= fg_color_i;
      s1_bg_q   <= bg_color_i;
    end
  end

  // Stage 2: area multiply and window ends.
  job_t job_q;

  assign s2_ready = !s2_valid_q || job_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      job_q.is_char   <= s1_char_q;
      job_q.x0        <= s1_x_q;
      job_q.y0        <= s1_y_q;
      job_q.x1        <= s1_x_q + s1_w_q - 8'd1;
      job_q.y1        <= s1_y_q + s1_h_q - 8'd1;
      job_q.count     <= s1_w_q * s1_h_q;
      job_q.char_code <= s1_code_q;
      job_q.fg        <= s1_fg_q;
      job_q.bg        <= s1_bg_q;
    end
  end

  assign job_valid_o = s2_valid_q;
  assign job_o       = job_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !job_ready_i |=> s2_valid_q && $stable(job_q))
    else $error("job dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !job_q.is_char |-> job_q.count != 16'd0)
    else $error("empty fill reached queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && job_q.is_char |-> job_q.count == 16'd48)
    else $error("bad character cell size");

endmodule

@@ hw/rtl/rgd_queue.sv @@
// Small job queue between the front and back ends.
module rgd_queue
  import rgd_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  job_t in_job_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output job_t out_job_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t            mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [AW:0]     cnt_q;
  logic            push, pop;

  assign in_ready_o  = cnt_q != (AW+1)'(Depth);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
      if (pop)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_job_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth)) else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + (AW+1)'(1)) else $error("queue count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - (AW+1)'(1)) else $error("queue count");

endmodule

@@ hw/rtl/rgd_back.sv @@
// Back end: sequence window set-up and pixel words for one job.
module rgd_back
  import rgd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  item_kind_o,
  output logic [15:0] item_value_o,
  output logic [15:0] repeat_count_o,
  output logic        last_item_o
);

  be_state_e   state_q, state_d;
  job_t        job_q;
  logic [3:0]  step_q, step_d;
  logic [2:0]  col_q, col_d;
  logic [2:0]  row_q, row_d;

  // Output register.
  logic        ov_q;
  logic [1:0]  kind_q;
  logic [15:0] val_q, rep_q;
  logic        last_q;

  logic        gen_valid, gen_last, take, adv;
  logic [1:0]  gen_kind;
  logic [15:0] gen_val, gen_rep;
  logic [7:0]  bits;

  assign adv  = !ov_q || out_ready_i;
  assign bits = font_col(job_q.char_code, col_q);

  always_comb begin
    gen_valid = 1'b0;
    gen_kind  = KIND_DATA;
    gen_val   = 16'h0;
    gen_rep   = 16'd1;
    gen_last  = 1'b0;
    case (state_q)
      BE_WINDOW: begin
        gen_valid = 1'b1;
        case (step_q)
          4'd0: begin gen_kind = KIND_CMD; gen_val = {8'h0, CMD_COLSET}; end
          4'd2: gen_val = {8'h0, job_q.x0};
          4'd4: gen_val = {8'h0, job_q.x1};
          4'd5: begin gen_kind = KIND_CMD; gen_val = {8'h0, CMD_ROWSET}; end
          4'd7: gen_val = {8'h0, job_q.y0};
          4'd9: gen_val = {8'h0, job_q.y1};
          4'd10: begin gen_kind = KIND_CMD; gen_val = {8'h0, CMD_MEMWR}; end
          default: gen_val = 16'h0;
        endcase
      end
      BE_CHAR: begin
        gen_valid = 1'b1;
        gen_kind  = KIND_PIXEL;
        gen_val   = bits[row_q] ? job_q.fg : job_q.bg;
        gen_last  = (row_q == 3'(CELL_H - 1)) && (col_q == 3'(CELL_W - 1));
      end
      BE_FILL: begin
        gen_valid = 1'b1;
        gen_kind  = KIND_PIXEL;
        gen_val   = job_q.fg;
        gen_rep   = job_q.count;
        gen_last  = 1'b1;
      end
      default: gen_valid = 1'b0;
    endcase
  end

  assign job_ready_o = (state_q == BE_IDLE) || (gen_last && adv);
  assign take        = job_valid_i && job_ready_o;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    col_d   = col_q;
    row_d   = row_q;
    if (gen_valid && adv) begin
      case (state_q)
        BE_WINDOW: begin
          step_d = step_q + 4'd1;
          if (step_q == 4'd10) state_d = job_q.is_char ? BE_CHAR : BE_FILL;
        end
        BE_CHAR: begin
          if (col_q == 3'(CELL_W - 1)) begin
            col_d = 3'd0;
            row_d = row_q + 3'd1;
          end else begin
            col_d = col_q + 3'd1;
          end
          if (gen_last) state_d = BE_IDLE;
        end
        BE_FILL: state_d = BE_IDLE;
        default: state_d = state_q;
      endcase
    end
    if (take) begin
      state_d = BE_WINDOW;
      step_d  = 4'd0;
      col_d   = 3'd0;
      row_d   = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_IDLE;
      step_q  <= 4'd0;
      col_q   <= 3'd0;
      row_q   <= 3'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (adv) ov_q <= gen_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) job_q <= job_i;
    if (adv && gen_valid) begin
      kind_q <= gen_kind;
      val_q  <= gen_val;
      rep_q  <= gen_rep;
      last_q <= gen_last;
    end
  end

  assign out_valid_o    = ov_q;
  assign item_kind_o    = kind_q;
  assign item_value_o   = val_q;
  assign repeat_count_o = rep_q;
  assign last_item_o    = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(val_q) && $stable(last_q))
    else $error("output word changed under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BE_WINDOW |-> step_q <= 4'd10) else $error("window step overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BE_CHAR |-> col_q < 3'(CELL_W)) else $error("column overrun");

endmodule

@@ hw/rtl/rect_and_glyph_draw_stream.sv @@
// Top level: drawing request in, panel command/data/pixel word stream out.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+---------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tuser: req_type; tdata: x,y,w,h,code,fg,bg
//  m_axis   | out | m_axis_tvalid/tready   | tuser: kind; tdata: value,repeat; tlast: last
//  cfg      | in  | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A character request produces 59 output words (11 set-up words, 48 pixels), a
// drawn fill 12; the back-end sequencer emits one word per cycle unless the
// output stalls. The first word of a request passes through the two front
// stages, the job queue, the back-end load and the output register.
// A two-entry job queue lets new requests enter while the back end drains
// earlier ones; the back end loads the next job as the last word advances.
// Reset clears all valid flags and sets the panel to 128 x 160.
// Output stalls hold the output register and back up through the queue.
module rect_and_glyph_draw_stream
  import rgd_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[0]
  input  logic        s_axis_tuser,
  // pos_x[7:0], pos_y[15:8], rect_width[23:16], rect_height[31:24],
  // char_code[39:32], fg_color[55:40], bg_color[71:56]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // item_kind[1:0]
  output logic [1:0]  m_axis_tuser,
  // item_value[15:0], repeat_count[31:16]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0] panel_width_q, panel_height_q;

  // Configuration writes; only the two listed indexes exist.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_width_q  <= 8'd128;
      panel_height_q <= 8'd160;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PANEL_WIDTH:  panel_width_q  <= cfg_data_i;
        CFG_PANEL_HEIGHT: panel_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  job_t fq_job, qb_job;
  logic [15:0] value, rep;

  rgd_front u_front (
    .clk_i, .rst_ni,
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .req_type_i    (s_axis_tuser),
    .pos_x_i       (s_axis_tdata[7:0]),
    .pos_y_i       (s_axis_tdata[15:8]),
    .rect_width_i  (s_axis_tdata[23:16]),
    .rect_height_i (s_axis_tdata[31:24]),
    .char_code_i   (s_axis_tdata[39:32]),
    .fg_color_i    (s_axis_tdata[55:40]),
    .bg_color_i    (s_axis_tdata[71:56]),
    .panel_width_i (panel_width_q),
    .panel_height_i(panel_height_q),
    .job_valid_o   (fq_valid),
    .job_ready_i   (fq_ready),
    .job_o         (fq_job)
  );

  rgd_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i (fq_valid),
    .in_ready_o (fq_ready),
    .in_job_i   (fq_job),
    .out_valid_o(qb_valid),
    .out_ready_i(qb_ready),
    .out_job_o  (qb_job)
  );

  rgd_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i   (qb_valid),
    .job_ready_o   (qb_ready),
    .job_i         (qb_job),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .item_kind_o   (m_axis_tuser),
    .item_value_o  (value),
    .repeat_count_o(rep),
    .last_item_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {rep, value};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word withdrawn");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("bad item kind");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_PIXEL)
    else $error("last word is not a pixel");

endmodule
